// ===== hdl/gbi_pkg.sv =====
// gbi_pkg: shared types and constants for the grid bilinear interpolator.
// No dependencies; the top, gbi_fifo, gbi_front and gbi_back refer to it by scoped names.
package gbi_pkg;

  localparam int FracBits      = 16;
  localparam int SampleW       = 24;
  localparam int CoordW        = 17;
  localparam int CfgW          = 9;
  localparam int WeightW       = FracBits + 1;
  localparam int ProdW         = SampleW + WeightW + 1;
  localparam int AccW          = ProdW + 2;
  localparam int WsumW         = WeightW + 2;
  localparam int MaxSamplesDef = 256;
  localparam int FifoDepthDef  = 4;
  // command fields sized for the largest supported grid (1024 per axis)
  localparam int AddrMaxW      = 20;
  localparam int IdxMaxW       = 12;

  localparam logic [CfgW-1:0] CfgReset = 9'd256;
  localparam logic            OpWrite  = 1'b0;
  localparam logic            OpQuery  = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [7:0]                row;
    logic [7:0]                column;
    logic signed [SampleW-1:0] write_value;
    logic [CoordW-1:0]         norm_x;
    logic [CoordW-1:0]         norm_z;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] interp_value;
    logic                      valid_res;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    logic                      is_query;
    logic [AddrMaxW-1:0]       addr;
    logic signed [SampleW-1:0] data;
    logic [IdxMaxW-1:0]        r;
    logic [IdxMaxW-1:0]        c;
    logic [FracBits-1:0]       fr;
    logic [FracBits-1:0]       fc;
  } cmd_t;

endpackage

// ===== hdl/grid_bilinear_interpolator_top.sv =====
// grid_bilinear_interpolator_top: a write word is executed by the back end as it is popped; a query holds the back
// end through pop, four corners of weight, read, multiply and accumulate, divider start, divider run and output;
// the divider run is skipped when no corner is used. The divider sets the query rate; words queue in front.
// Reset is asynchronous, active low; afterwards the grid is zeroed one entry per cycle,
// all 2**AW addresses (65536 by default), with full_o held high meanwhile.
// Depends on gbi_pkg, gbi_front, gbi_fifo, gbi_back, gbi_div and gbi_ram.
module grid_bilinear_interpolator_top #(
  parameter int MAX_SAMPLES = gbi_pkg::MaxSamplesDef,
  parameter int FIFO_DEPTH  = gbi_pkg::FifoDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config: samples_per_axis
  input  logic                      cfg_we_i,
  input  logic [gbi_pkg::CfgW-1:0]  cfg_wdata_i,
  // input queue side
  input  logic                      push_i,
  input  gbi_pkg::in_t              in_i,
  output logic                      full_o,
  // result queue side
  input  logic                      pop_i,
  output logic                      empty_o,
  output gbi_pkg::out_t             out_o
);

  localparam int NW = $clog2(MAX_SAMPLES+1);
  localparam int AW = $clog2(MAX_SAMPLES*MAX_SAMPLES);

  logic [gbi_pkg::CfgW-1:0] spa_q;
  logic [NW-1:0]            n;

  logic                     accept;
  logic                     cmd_push, cmd_full, cmd_valid, cmd_pop, clearing;
  gbi_pkg::cmd_t            cmd_in, cmd_out;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [gbi_pkg::SampleW-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q <= gbi_pkg::CfgReset;
    end else if (cfg_we_i) begin
      spa_q <= cfg_wdata_i;
    end
  end

  // active size, saturated into 2..MAX_SAMPLES
  always_comb begin
    if (int'(spa_q) < 2) begin
      n = NW'(2);
    end else if (int'(spa_q) > MAX_SAMPLES) begin
      n = NW'(MAX_SAMPLES);
    end else begin
      n = NW'(spa_q);
    end
  end

  // no words are taken while the grid is being zeroed
  assign full_o = cmd_full || clearing;
  assign accept = push_i && !full_o;

  gbi_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .in_i       (in_i),
    .accept_i   (accept),
    .n_i        (n),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  gbi_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  gbi_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_o)
  );

  // height grid
  gbi_ram #(
    .WIDTH(gbi_pkg::SampleW),
    .DEPTH(MAX_SAMPLES*MAX_SAMPLES)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hdl/gbi_ram.sv =====
// gbi_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module gbi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/gbi_fifo.sv =====
// gbi_fifo: small command queue between the front and back parts.
// Depends on gbi_pkg (cmd_t).
module gbi_fifo #(
  parameter int DEPTH = gbi_pkg::FifoDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbi_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gbi_pkg::cmd_t data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gbi_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]    cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/gbi_front.sv =====
// gbi_front: classifies accepted words into commands (grid address or cell/fraction).
// Depends on gbi_pkg.
module gbi_front #(
  parameter int MAX_SAMPLES = gbi_pkg::MaxSamplesDef
) (
  input  gbi_pkg::in_t                    in_i,
  input  logic                            accept_i,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] n_i,
  output logic                            cmd_push_o,
  output gbi_pkg::cmd_t                   cmd_o
);

  localparam int NW = $clog2(MAX_SAMPLES+1);
  localparam int RW = NW + 1;
  localparam int AW = $clog2(MAX_SAMPLES*MAX_SAMPLES);
  localparam int SW = gbi_pkg::CoordW + NW;
  localparam int F  = gbi_pkg::FracBits;

  logic [SW-1:0]   sx, sz;
  logic [8+NW-1:0] wprod;
  logic [8+NW:0]   wsum;
  logic            in_grid;

  always_comb begin
    sx      = SW'(in_i.norm_x) * SW'(n_i);
    sz      = SW'(in_i.norm_z) * SW'(n_i);
    wprod   = (8+NW)'(in_i.row) * (8+NW)'(n_i);
    wsum    = (9+NW)'(wprod) + (9+NW)'(in_i.column);
    in_grid = ((8+NW)'(in_i.row) < (8+NW)'(n_i)) &&
              ((8+NW)'(in_i.column) < (8+NW)'(n_i));

    cmd_o          = '0;
    cmd_o.is_query = (in_i.operation == gbi_pkg::OpQuery);
    cmd_o.addr     = gbi_pkg::AddrMaxW'(wsum[AW-1:0]);
    cmd_o.data     = in_i.write_value;
    cmd_o.r        = gbi_pkg::IdxMaxW'(sx[F +: RW]);
    cmd_o.c        = gbi_pkg::IdxMaxW'(sz[F +: RW]);
    cmd_o.fr       = sx[F-1:0];
    cmd_o.fc       = sz[F-1:0];

    // writes outside the active grid are dropped here
    cmd_push_o = accept_i && (cmd_o.is_query || in_grid);
  end

endmodule

// ===== hdl/gbi_div.sv =====
// gbi_div: unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module gbi_div #(
  parameter int DW = 44,
  parameter int VW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);

  localparam int CW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q, div_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   rem_sh, rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

// ===== hdl/gbi_back.sv =====
// gbi_back: clears the grid, executes writes and runs the four-corner query sequence.
// Depends on gbi_pkg and gbi_div; drives the grid RAM ports.
module gbi_back #(
  parameter int MAX_SAMPLES = gbi_pkg::MaxSamplesDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]              n_i,
  input  logic                                          cmd_valid_i,
  input  gbi_pkg::cmd_t                                 cmd_i,
  output logic                                          cmd_pop_o,
  output logic                                          clearing_o,
  output logic                                          ram_we_o,
  output logic [$clog2(MAX_SAMPLES*MAX_SAMPLES)-1:0]    ram_waddr_o,
  output logic [gbi_pkg::SampleW-1:0]                   ram_wdata_o,
  output logic                                          ram_re_o,
  output logic [$clog2(MAX_SAMPLES*MAX_SAMPLES)-1:0]    ram_raddr_o,
  input  logic [gbi_pkg::SampleW-1:0]                   ram_rdata_i,
  input  logic                                          pop_i,
  output logic                                          empty_o,
  output gbi_pkg::out_t                                 out_o
);

  localparam int NW = $clog2(MAX_SAMPLES+1);
  localparam int RW = NW + 1;
  localparam int AW = $clog2(MAX_SAMPLES*MAX_SAMPLES);
  localparam int F  = gbi_pkg::FracBits;
  localparam int WW = gbi_pkg::WeightW;
  localparam int PW = gbi_pkg::ProdW;
  localparam int CW = gbi_pkg::AccW;
  localparam int SW = gbi_pkg::WsumW;
  localparam int DW = gbi_pkg::SampleW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WGT   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MAC   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]           state_q;
  logic [AW-1:0]        clr_q;
  logic [1:0]           k_q;
  logic                 out_valid_q;

  gbi_pkg::cmd_t        cmd_q;
  logic [WW-1:0]        w_q;
  logic [AW-1:0]        addr_q;
  logic                 use_q;
  logic signed [PW-1:0] prod_q;
  logic signed [CW-1:0] acc_q;
  logic [SW-1:0]        wsum_q;
  logic                 neg_q;
  logic signed [DW-1:0] res_q;
  logic                 res_ok_q;
  gbi_pkg::out_t        out_q;

  // corner evaluation
  logic                 kr, kc;
  logic [RW-1:0]        rk, ck;
  logic [WW-1:0]        fa, fb, w_new;
  logic [2*WW-1:0]      wprod;
  logic [RW+NW-1:0]     aprod, asum;
  logic                 in_grid;
  logic [CW-1:0]        acc_mag;
  logic                 div_start, div_done;
  logic [CW-1:0]        quo;
  logic [DW-1:0]        q_lo;
  logic                 out_load;

  localparam logic [WW-1:0] One = WW'(1) << F;

  always_comb begin
    kr      = (k_q == 2'd1) || (k_q == 2'd2);
    kc      = (k_q == 2'd2) || (k_q == 2'd3);
    rk      = cmd_q.r[RW-1:0] + RW'(kr);
    ck      = cmd_q.c[RW-1:0] + RW'(kc);
    fa      = kr ? {1'b0, cmd_q.fr} : One - {1'b0, cmd_q.fr};
    fb      = kc ? {1'b0, cmd_q.fc} : One - {1'b0, cmd_q.fc};
    wprod   = fa * fb;
    w_new   = wprod[F +: WW];
    in_grid = (rk < RW'(n_i)) && (ck < RW'(n_i));
    aprod   = (RW+NW)'(rk) * (RW+NW)'(n_i);
    asum    = aprod + (RW+NW)'(ck);
  end

  assign acc_mag    = acc_q[CW-1] ? CW'(-acc_q) : CW'(acc_q);
  assign div_start  = (state_q == S_DIVGO) && (wsum_q != '0);
  assign q_lo       = quo[DW-1:0];
  // result register takes a new word when it is free or being popped
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || pop_i);

  assign clearing_o = (state_q == S_CLEAR);
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign ram_we_o   = clearing_o || (cmd_pop_o && !cmd_i.is_query);
  assign ram_waddr_o = clearing_o ? clr_q : cmd_i.addr[AW-1:0];
  assign ram_wdata_o = clearing_o ? '0 : cmd_i.data;
  assign ram_re_o    = (state_q == S_RD);
  assign ram_raddr_o = addr_q;
  assign empty_o     = !out_valid_q;
  assign out_o       = out_q;

  gbi_div #(
    .DW(CW),
    .VW(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_mag),
    .divisor_i  (wsum_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i && cmd_i.is_query) begin
            k_q     <= '0;
            state_q <= S_WGT;
          end
        end
        S_WGT: state_q <= S_RD;
        S_RD:  state_q <= S_MAC;
        S_MAC: state_q <= S_ACC;
        S_ACC: begin
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? S_DIVGO : S_WGT;
        end
        S_DIVGO: state_q <= (wsum_q == '0) ? S_OUT : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_i.is_query) begin
          cmd_q  <= cmd_i;
          acc_q  <= '0;
          wsum_q <= '0;
        end
      end
      S_WGT: begin
        w_q    <= w_new;
        addr_q <= asum[AW-1:0];
        use_q  <= in_grid && (w_new != '0);
      end
      S_MAC: prod_q <= $signed(ram_rdata_i) * $signed({1'b0, w_q});
      S_ACC: begin
        if (use_q) begin
          acc_q  <= acc_q + {{(CW-PW){prod_q[PW-1]}}, prod_q};
          wsum_q <= wsum_q + SW'(w_q);
        end
      end
      S_DIVGO: begin
        neg_q    <= acc_q[CW-1];
        res_q    <= '0;
        res_ok_q <= (wsum_q != '0);
      end
      S_DIV: begin
        if (div_done) begin
          res_q <= neg_q ? -$signed(q_lo) : $signed(q_lo);
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_q.interp_value <= res_q;
          out_q.valid_res    <= res_ok_q;
        end
      end
      default: ;
    endcase
  end

endmodule
